@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the ucd_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ucd_pkg.sv @@
// ----------------------------------------------------------------------------
// ucd_pkg
// Types and constants shared by the seconds-to-civil-date pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucd_pkg;

    // Pipeline depth of each section.
    localparam int SPLIT_STAGES = 3;
    localparam int CAL_STAGES   = 10;
    localparam int PIPE_STAGES  = SPLIT_STAGES + CAL_STAGES + 1;

    // Field widths.
    localparam int SECS_W   = 32;
    localparam int DAYS_W   = 16;
    localparam int SOD_W    = 17;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OUT_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    // Reciprocals, each floor(2^k / d) with k at least the dividend width.
    localparam logic [15:0] RECIP_675  = 16'd49710;  // k = 25
    localparam logic [7:0]  RECIP_1460 = 8'd179;     // k = 18
    localparam logic [9:0]  RECIP_365  = 10'd718;    // k = 18
    localparam logic [5:0]  RECIP_3600 = 6'd36;      // k = 17
    localparam logic [6:0]  RECIP_60   = 7'd68;      // k = 12

    // Day-count constants of the March-based era.
    localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
    localparam logic [19:0] ERA5_START    = 20'd730485;
    localparam logic [19:0] ERA4_START    = 20'd584388;
    localparam logic [11:0] ERA4_YEAR     = 12'd1600;
    localparam logic [11:0] ERA5_YEAR     = 12'd2000;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } tod_t;

    // First day of year, counted from March 1, of each March-based month.
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

@@ hdl/ucd_split.sv @@
// ----------------------------------------------------------------------------
// ucd_split
// Splits a seconds count into whole days and seconds of day (three stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucd_split (
    input  logic                          aclk,
    input  logic [ucd_pkg::SPLIT_STAGES-1:0] en,
    input  logic [ucd_pkg::SECS_W-1:0]   epoch_seconds,
    output logic [ucd_pkg::DAYS_W-1:0]   days,
    output logic [ucd_pkg::SOD_W-1:0]    sod
);

    // 86400 = 128 * 675: the low seven bits pass straight into the remainder.
    logic [31:0] secs_reg;
    logic [40:0] prod_reg;
    logic [15:0] est_reg;
    logic [10:0] rem_reg;
    logic [6:0]  lo_reg;
    logic [15:0] days_reg;
    logic [16:0] sod_reg;

    logic [24:0] rem_full;
    logic        fix;
    logic [10:0] rem_fixed;

    assign rem_full  = secs_reg[31:7] - 25'(26'(prod_reg[40:25]) * 26'd675);
    assign fix       = (rem_reg >= 11'd675);
    assign rem_fixed = fix ? (rem_reg - 11'd675) : rem_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            secs_reg <= epoch_seconds;
            prod_reg <= 41'(epoch_seconds[31:7]) * 41'(ucd_pkg::RECIP_675);
        end
        if (en[1]) begin
            est_reg <= prod_reg[40:25];
            rem_reg <= rem_full[10:0];
            lo_reg  <= secs_reg[6:0];
        end
        if (en[2]) begin
            days_reg <= est_reg + 16'(fix);
            sod_reg  <= {rem_fixed[9:0], lo_reg};
        end
    end

    assign days = days_reg;
    assign sod  = sod_reg;

endmodule

@@ hdl/ucd_tod.sv @@
// ----------------------------------------------------------------------------
// ucd_tod
// Splits seconds of day into hour, minute and second, delay-matched to the
// calendar path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucd_tod (
    input  logic                           aclk,
    input  logic [ucd_pkg::CAL_STAGES-1:0] en,
    input  logic [ucd_pkg::SOD_W-1:0]      sod,
    output ucd_pkg::tod_t                  tod
);

    localparam int DLY = ucd_pkg::CAL_STAGES - 6;

    logic [16:0] sod0_reg;
    logic [22:0] ph_reg;
    logic [4:0]  hest_reg;
    logic [12:0] hrem_reg;
    logic [4:0]  hour2_reg;
    logic [11:0] soh2_reg;
    logic [4:0]  hour3_reg;
    logic [11:0] soh3_reg;
    logic [18:0] pm_reg;
    logic [4:0]  hour4_reg;
    logic [5:0]  mest_reg;
    logic [6:0]  mrem_reg;
    ucd_pkg::tod_t dly_reg [DLY+1];

    logic [16:0] hrem_full;
    logic        hfix;
    logic [11:0] mrem_full;
    logic        mfix;
    logic [6:0]  mrem_fixed;

    assign hrem_full  = sod0_reg - 17'(17'(ph_reg[21:17]) * 17'd3600);
    assign hfix       = (hrem_reg >= 13'd3600);
    assign mrem_full  = soh3_reg - 12'(12'(pm_reg[17:12]) * 12'd60);
    assign mfix       = (mrem_reg >= 7'd60);
    assign mrem_fixed = mfix ? (mrem_reg - 7'd60) : mrem_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sod0_reg <= sod;
            ph_reg   <= 23'(sod) * 23'(ucd_pkg::RECIP_3600);
        end
        if (en[1]) begin
            hest_reg <= ph_reg[21:17];
            hrem_reg <= hrem_full[12:0];
        end
        if (en[2]) begin
            hour2_reg <= hest_reg + 5'(hfix);
            soh2_reg  <= hfix ? 12'(hrem_reg - 13'd3600) : hrem_reg[11:0];
        end
        if (en[3]) begin
            hour3_reg <= hour2_reg;
            soh3_reg  <= soh2_reg;
            pm_reg    <= 19'(soh2_reg) * 19'(ucd_pkg::RECIP_60);
        end
        if (en[4]) begin
            hour4_reg <= hour3_reg;
            mest_reg  <= pm_reg[17:12];
            mrem_reg  <= mrem_full[6:0];
        end
        if (en[5]) begin
            dly_reg[0].hour   <= hour4_reg;
            dly_reg[0].minute <= mest_reg + 6'(mfix);
            dly_reg[0].second <= mrem_fixed[5:0];
        end
    end

    // Delay line that aligns the result with the calendar path.
    for (genvar i = 1; i <= DLY; i++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en[5+i]) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign tod = dly_reg[DLY];

endmodule

@@ hdl/ucd_date.sv @@
// ----------------------------------------------------------------------------
// ucd_date
// Converts a day count since the epoch to year, month and day of month
// through a March-based era, one constant division per pair of stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucd_date (
    input  logic                           aclk,
    input  logic [ucd_pkg::CAL_STAGES-1:0] en,
    input  logic [ucd_pkg::DAYS_W-1:0]     days,
    output ucd_pkg::date_t                 date
);

    // Stage 0: era and day of era.
    logic [17:0] doe0_reg;
    logic        era0_reg;
    // Stage 1: doe / 1460 product, century terms.
    logic [17:0] doe1_reg;
    logic        era1_reg;
    logic [25:0] pa_reg;
    logic [2:0]  qc1_reg;
    // Stage 2: doe / 1460 estimate.
    logic [17:0] doe2_reg;
    logic        era2_reg;
    logic [2:0]  qc2_reg;
    logic [7:0]  aest_reg;
    logic [11:0] arem_reg;
    // Stage 3: day count with leap days removed.
    logic [17:0] doe3_reg;
    logic        era3_reg;
    logic [17:0] t3_reg;
    // Stage 4: t / 365 product.
    logic [17:0] doe4_reg;
    logic        era4_reg;
    logic [17:0] t4_reg;
    logic [26:0] pb_reg;
    // Stage 5: t / 365 estimate.
    logic [17:0] doe5_reg;
    logic        era5_reg;
    logic [8:0]  best_reg;
    logic [9:0]  brem_reg;
    // Stage 6: year of era.
    logic [17:0] doe6_reg;
    logic        era6_reg;
    logic [8:0]  yoe6_reg;
    // Stage 7: day of year and March-based year.
    logic [8:0]  doy7_reg;
    logic [11:0] year7_reg;
    // Stage 8: March-based month.
    logic [8:0]  doy8_reg;
    logic [11:0] year8_reg;
    logic [3:0]  mp8_reg;
    // Stage 9: result.
    ucd_pkg::date_t date_reg;

    logic [19:0] shifted;
    logic        era5;
    logic [19:0] doe_full;
    logic [2:0]  qc;
    logic [17:0] arem_full;
    logic [7:0]  aq;
    logic [17:0] brem_full;
    logic [17:0] ybase;
    logic [1:0]  ycent;
    logic [17:0] doy_full;
    logic [3:0]  mp;
    logic [8:0]  day_full;
    logic [3:0]  month;

    assign shifted  = 20'(days) + ucd_pkg::DAYS_TO_EPOCH;
    assign era5     = (shifted >= ucd_pkg::ERA5_START);
    assign doe_full = shifted - (era5 ? ucd_pkg::ERA5_START : ucd_pkg::ERA4_START);

    // doe / 36524 - doe / 146096 over the day-of-era range.
    assign qc = 3'(doe0_reg >= 18'd36524) + 3'(doe0_reg >= 18'd73048)
              + 3'(doe0_reg >= 18'd109572) + 3'(doe0_reg >= 18'd146096)
              - 3'(doe0_reg == 18'd146096);

    assign arem_full = doe1_reg - 18'(18'(pa_reg[25:18]) * 18'd1460);
    assign aq        = aest_reg + 8'(arem_reg >= 12'd1460);
    assign brem_full = t4_reg - 18'(18'(pb_reg[26:18]) * 18'd365);

    assign ycent    = 2'(yoe6_reg >= 9'd100) + 2'(yoe6_reg >= 9'd200)
                    + 2'(yoe6_reg >= 9'd300);
    assign ybase    = 18'(yoe6_reg) * 18'd365 + 18'(yoe6_reg[8:2]) - 18'(ycent);
    assign doy_full = doe6_reg - ybase;

    always_comb begin
        mp = '0;
        for (int k = 1; k < 12; k++) begin
            mp = mp + 4'(doy7_reg >= ucd_pkg::month_offset(4'(k)));
        end
    end

    assign day_full = doy8_reg - ucd_pkg::month_offset(mp8_reg) + 9'd1;
    assign month    = (mp8_reg < 4'd10) ? (mp8_reg + 4'd3) : (mp8_reg - 4'd9);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            doe0_reg <= doe_full[17:0];
            era0_reg <= era5;
        end
        if (en[1]) begin
            doe1_reg <= doe0_reg;
            era1_reg <= era0_reg;
            pa_reg   <= 26'(doe0_reg) * 26'(ucd_pkg::RECIP_1460);
            qc1_reg  <= qc;
        end
        if (en[2]) begin
            doe2_reg <= doe1_reg;
            era2_reg <= era1_reg;
            qc2_reg  <= qc1_reg;
            aest_reg <= pa_reg[25:18];
            arem_reg <= arem_full[11:0];
        end
        if (en[3]) begin
            doe3_reg <= doe2_reg;
            era3_reg <= era2_reg;
            t3_reg   <= doe2_reg - 18'(aq) + 18'(qc2_reg);
        end
        if (en[4]) begin
            doe4_reg <= doe3_reg;
            era4_reg <= era3_reg;
            t4_reg   <= t3_reg;
            pb_reg   <= 27'(t3_reg) * 27'(ucd_pkg::RECIP_365);
        end
        if (en[5]) begin
            doe5_reg <= doe4_reg;
            era5_reg <= era4_reg;
            best_reg <= pb_reg[26:18];
            brem_reg <= brem_full[9:0];
        end
        if (en[6]) begin
            doe6_reg <= doe5_reg;
            era6_reg <= era5_reg;
            yoe6_reg <= best_reg + 9'(brem_reg >= 10'd365);
        end
        if (en[7]) begin
            doy7_reg  <= doy_full[8:0];
            year7_reg <= 12'(yoe6_reg)
                       + (era6_reg ? ucd_pkg::ERA5_YEAR : ucd_pkg::ERA4_YEAR);
        end
        if (en[8]) begin
            doy8_reg  <= doy7_reg;
            year8_reg <= year7_reg;
            mp8_reg   <= mp;
        end
        if (en[9]) begin
            // The era year starts in March, so January and February belong
            // to the next calendar year.
            date_reg.year  <= year8_reg + 12'(month <= 4'd2);
            date_reg.month <= month;
            date_reg.day   <= day_full[4:0];
        end
    end

    assign date = date_reg;

endmodule

@@ hdl/unix_seconds_to_civil_datetime_top.sv @@
// ----------------------------------------------------------------------------
// unix_seconds_to_civil_datetime_top
// Converts unsigned seconds since 1970-01-01 00:00:00 UTC to the proleptic
// Gregorian date and time of day, one transfer per cycle while not stalled.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Bits  Contents
//   s_axis    in         32    epoch_seconds
//   m_axis    out        40    year, month, day_of_month, hour, minute, second
//
// A new transfer can be taken on every clock cycle while any stage has room;
// each one reaches the result side through 3 split stages, 10 calendar stages
// and the output register. The depth is set by the chain of constant
// divisions in the calendar path. A synchronous active-low reset empties every
// stage; data registers are not cleared. A stall on m_tready holds only the
// stages that are full up to the first empty one, so bubbles are squeezed out
// and s_tready stays high while any stage has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unix_seconds_to_civil_datetime_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [11:0] year, [15:12] month,
                                   // [20:16] day_of_month, [25:21] hour,
                                   // [31:26] minute, [37:32] second,
                                   // [39:38] zero
);

    localparam int NS = ucd_pkg::PIPE_STAGES;
    localparam int SS = ucd_pkg::SPLIT_STAGES;
    localparam int CS = ucd_pkg::CAL_STAGES;

    // One valid bit per stage; the last one is the output register.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    logic [ucd_pkg::DAYS_W-1:0] days;
    logic [ucd_pkg::SOD_W-1:0]  sod;
    ucd_pkg::date_t             date;
    ucd_pkg::tod_t              tod;
    logic [ucd_pkg::OUT_BYTES_W-1:0] out_reg;

    // A stage may load when it is empty or when the stage after it loads.
    assign en[NS-1] = !valid_reg[NS-1] || m_tready;
    for (genvar i = 0; i < NS - 1; i++) begin : g_en
        assign en[i] = !valid_reg[i] || en[i+1];
    end

    assign valid_next[0] = s_tvalid;
    for (genvar i = 1; i < NS; i++) begin : g_vnext
        assign valid_next[i] = valid_reg[i-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    ucd_split u_split (
        .aclk          (aclk),
        .en            (en[SS-1:0]),
        .epoch_seconds (s_tdata),
        .days          (days),
        .sod           (sod)
    );

    ucd_date u_date (
        .aclk (aclk),
        .en   (en[SS+CS-1:SS]),
        .days (days),
        .date (date)
    );

    ucd_tod u_tod (
        .aclk (aclk),
        .en   (en[SS+CS-1:SS]),
        .sod  (sod),
        .tod  (tod)
    );

    // Output register: fields packed from the lowest bit up.
    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            out_reg <= ucd_pkg::OUT_BYTES_W'({tod.second, tod.minute, tod.hour,
                                              date.day, date.month, date.year});
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = out_reg;

endmodule

@@ hdl/ucd_checker.sv @@
// ----------------------------------------------------------------------------
// ucd_checker
// Port-level checks on the seconds-to-civil-date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ucd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic in_xfer;
    logic date_ok;
    logic time_ok;

    assign in_xfer = s_tvalid && s_tready && (s_tdata == s_tdata);

    assign date_ok = (m_tdata[11:0] >= 12'd1970) && (m_tdata[11:0] <= 12'd2106)
                  && (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12)
                  && (m_tdata[20:16] >= 5'd1);
    assign time_ok = (m_tdata[25:21] <= 5'd23) && (m_tdata[31:26] <= 6'd59)
                  && (m_tdata[37:32] <= 6'd59) && (m_tdata[39:38] == 2'd0);

    // A ready sink lets the whole pipeline advance, so the source is never held.
    `ASSERT_IMP(a_ready_path, aclk, aresetn, m_tready, s_tready || !in_xfer && s_tready, "s_tready low while m_tready high")
    `ASSERT_IMP(a_date_range, aclk, aresetn, m_tvalid, date_ok, "date field out of range")
    `ASSERT_IMP(a_time_range, aclk, aresetn, m_tvalid, time_ok, "time field out of range")
    `ASSERT_NXT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped during stall")
    `ASSERT_NXT(a_data_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed during stall")

endmodule

bind unix_seconds_to_civil_datetime_top ucd_checker u_checker (.*);

@@ dv/civil_datetime_checker.sv @@
// ----------------------------------------------------------------------------
// civil_datetime_checker
// Watches both stream channels of the seconds-to-civil-date converter,
// predicts the calendar date and time for every accepted timestamp and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module civil_datetime_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [11:0] year, [15:12] month,
                                   // [20:16] day_of_month, [25:21] hour,
                                   // [31:26] minute, [37:32] second
    output int          mismatch_count,
    output int          results_due
);

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [31:0] EPOCH_DAY     = 32'd719468;   // 0000-03-01 to 1970-01-01
    localparam logic [31:0] ERA_DAYS      = 32'd146097;   // days in 400 years

    typedef struct packed {
        logic [ucd_pkg::YEAR_W-1:0]   year;
        logic [ucd_pkg::MONTH_W-1:0]  month;
        logic [ucd_pkg::DAY_W-1:0]    day_of_month;
        logic [ucd_pkg::HOUR_W-1:0]   hour;
        logic [ucd_pkg::MINUTE_W-1:0] minute;
        logic [ucd_pkg::SECOND_W-1:0] second;
    } civil_t;

    civil_t expected_dates[$];
    int     errors = 0;

    // Calendar is counted from March so that the leap day falls at the end of
    // the year; January and February then belong to the following year.
    function automatic civil_t civil_from_epoch(input logic [31:0] secs);
        logic [31:0] day_count;
        logic [31:0] sec_of_day;
        logic [31:0] shifted;
        logic [31:0] era;
        logic [31:0] day_of_era;
        logic [31:0] year_of_era;
        logic [31:0] full_year;
        logic [31:0] day_of_year;
        logic [31:0] march_month;
        logic [31:0] mon;
        logic [31:0] sec_of_hour;
        civil_t      res;
        day_count   = secs / SECS_PER_DAY;
        sec_of_day  = secs % SECS_PER_DAY;
        shifted     = day_count + EPOCH_DAY;
        era         = shifted / ERA_DAYS;
        day_of_era  = shifted % ERA_DAYS;
        year_of_era = (day_of_era - day_of_era / 32'd1460 + day_of_era / 32'd36524
                       - day_of_era / 32'd146096) / 32'd365;
        full_year   = year_of_era + era * 32'd400;
        day_of_year = day_of_era - (32'd365 * year_of_era + year_of_era / 32'd4
                                    - year_of_era / 32'd100);
        march_month = (32'd5 * day_of_year + 32'd2) / 32'd153;
        mon         = (march_month < 32'd10) ? march_month + 32'd3 : march_month - 32'd9;
        if (mon <= 32'd2)
            full_year = full_year + 32'd1;
        sec_of_hour = sec_of_day % SECS_PER_HOUR;

        res.year         = full_year[ucd_pkg::YEAR_W-1:0];
        res.month        = mon[ucd_pkg::MONTH_W-1:0];
        res.day_of_month = 5'(day_of_year - (32'd153 * march_month + 32'd2) / 32'd5 + 32'd1);
        res.hour         = 5'(sec_of_day / SECS_PER_HOUR);
        res.minute       = 6'(sec_of_hour / SECS_PER_MIN);
        res.second       = 6'(sec_of_hour % SECS_PER_MIN);
        return res;
    endfunction

    function automatic int field_differs(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // The result side is looked at first so that a transfer arriving in the
    // same cycle as an input can never be matched against that input.
    always @(posedge aclk) begin : watch
        civil_t want;
        civil_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.year         = m_tdata[11:0];
                got.month        = m_tdata[15:12];
                got.day_of_month = m_tdata[20:16];
                got.hour         = m_tdata[25:21];
                got.minute       = m_tdata[31:26];
                got.second       = m_tdata[37:32];
                if (expected_dates.size() == 0) begin
                    $error("result transfer with nothing expected, data %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_dates.pop_front();
                    errors += field_differs("year", want.year, got.year);
                    errors += field_differs("month", want.month, got.month);
                    errors += field_differs("day_of_month", want.day_of_month,
                                            got.day_of_month);
                    errors += field_differs("hour", want.hour, got.hour);
                    errors += field_differs("minute", want.minute, got.minute);
                    errors += field_differs("second", want.second, got.second);
                end
            end
            if (s_tvalid && s_tready)
                expected_dates.push_back(civil_from_epoch(s_tdata));
        end
        mismatch_count <= errors;
        results_due    <= expected_dates.size();
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives timestamps into the seconds-to-civil-date converter and gives the
// verdict. Calendar edge cases come first, then mostly random timestamps with
// idle bursts on both channels, a long receiver stall that backs the pipeline
// up, and a calm final stretch with no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    // A correct run stays far below this limit even with every gap and stall at
    // its worst, so the limit only trips on a hang.
    localparam int CYCLE_LIMIT  = 400000;
    // Long enough for the whole pipeline to fill and push back on the input.
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_ITEMS   = 40;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_ITEMS   = 150;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int mismatch_count;
    int results_due;
    int cycle_count = 0;

    // Shared between the sender and the receiver processes. The sender raises
    // hold_req to ask for the long receiver stall; the receiver clears it once
    // the stall is over. calm switches off idling on both channels.
    logic hold_req = 1'b0;
    logic calm     = 1'b0;

    unix_seconds_to_civil_datetime_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    civil_datetime_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one timestamp, optionally after an idle burst, and returns at the
    // edge where the transfer was accepted. tvalid is left high so that the
    // next call can present its item straight away without a dropout.
    task automatic send_epoch(input logic [31:0] secs, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 13);
    endfunction

    // Random timestamps weighted toward the places where the calendar logic
    // is most likely to slip: midnight, the turn of the year, the end of
    // February and the very top of the 32-bit range.
    function automatic logic [31:0] pick_epoch();
        int unsigned yr;
        int unsigned day_num;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6: begin
                // Last second or one of the first four seconds of a random day.
                day_num = $urandom_range(0, 49709);
                return day_num * 86400 + ($urandom_range(0, 1) ? 86399 : $urandom_range(0, 3));
            end
            7: begin
                // Around February 28 through March 2 of a random year.
                yr      = $urandom_range(1970, 2105);
                day_num = (yr - 1970) * 1461 / 4 + 57 + $urandom_range(0, 4);
                return day_num * 86400 + $urandom_range(0, 86399);
            end
            8: begin
                // Around December 31 and January 1.
                yr      = $urandom_range(1971, 2106);
                day_num = (yr - 1970) * 1461 / 4 + $urandom_range(0, 2) - 1;
                return day_num * 86400 + $urandom_range(0, 86399);
            end
            default: return 32'hFFFF_FFFF - $urandom_range(0, 86400 * 60);
        endcase
    endfunction

    // Receiver: random stalls, the one long hold on request, and no stalls at
    // all once the calm stretch starts.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Sender and verdict.
    initial begin
        logic [31:0] edge_cases[$];

        // Epoch start, minute, hour and day boundaries, the signed 32-bit
        // rollover, leap days in 1972 and 2000, the non-leap end of February
        // 2100, the turn of the millennium and the last representable second.
        edge_cases = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
                       32'd86399, 32'd86400, 32'd68169600, 32'd946684799,
                       32'd946684800, 32'd951782400, 32'd951868799, 32'd951868800,
                       32'd978307199, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'd4107542399, 32'd4107542400, 32'd4291747199,
                       32'd4291747200, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (edge_cases[i])
            send_epoch(edge_cases[i], pick_gap());

        // Pause with nothing in flight before the back-pressure test. The
        // outstanding count is registered, so it is first looked at after the next edge.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);

        // The receiver holds off while the sender keeps offering back to back
        // transfers, so the pipeline fills and s_tready has to drop.
        hold_req = 1'b1;
        repeat (HOLD_ITEMS) send_epoch(pick_epoch(), 0);

        repeat (RANDOM_ITEMS) send_epoch(pick_epoch(), pick_gap());

        // Calm stretch: full throughput in both directions.
        calm = 1'b1;
        repeat (CALM_ITEMS) send_epoch(pick_epoch(), 0);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        // Any stray result still inside the pipeline would show up here.
        repeat (2 * ucd_pkg::PIPE_STAGES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ucd_pkg.sv
hdl/ucd_split.sv
hdl/ucd_tod.sv
hdl/ucd_date.sv
hdl/unix_seconds_to_civil_datetime_top.sv
hdl/ucd_checker.sv
dv/civil_datetime_checker.sv
dv/tb_top.sv
